>>> rtl/core/tptm_pkg.sv
package tptm_pkg;

    localparam int NUM_SPACES        = 4;
    localparam int NUM_TABLES        = 16;
    localparam int ENTRIES_PER_TABLE = 1024;
    localparam int DIR_SLOTS         = 1024;

    localparam int OP_W    = 3;
    localparam int SPACE_W = 2;
    localparam int ADDR_W  = 32;
    localparam int FLAG_W  = 12;
    localparam int IDX_W   = 10;
    localparam int PAGE_W  = ADDR_W - FLAG_W;
    localparam int DIR_SHIFT = 22;
    localparam int TBL_SHIFT = 12;

    localparam int TBL_W     = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int CNT_W     = $clog2(NUM_TABLES + 1);
    localparam int DIR_DEPTH = NUM_SPACES * DIR_SLOTS;
    localparam int DIR_AW    = $clog2(DIR_DEPTH);
    localparam int TAB_DEPTH = NUM_TABLES * ENTRIES_PER_TABLE;
    localparam int TAB_AW    = $clog2(TAB_DEPTH);
    localparam int CLR_DEPTH = (DIR_DEPTH > TAB_DEPTH) ? DIR_DEPTH : TAB_DEPTH;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    localparam logic [ADDR_W-1:0] PRESENT_BIT = 32'h0000_0001;

    typedef enum logic [OP_W-1:0] {
        OP_MAP       = 3'd0,
        OP_UNMAP     = 3'd1,
        OP_SET_FLAGS = 3'd2,
        OP_CLR_FLAGS = 3'd3,
        OP_XLATE     = 3'd4,
        OP_GET_FLAGS = 3'd5
    } t_op;

    // Classified item as it sits in the queue
    typedef struct packed {
        logic                is_map;
        logic                is_unmap;
        logic                is_set;
        logic                is_clr;
        logic                is_xlate;
        logic                is_getf;
        logic                space_ok;
        logic [SPACE_W-1:0]  space;
        logic [ADDR_W-1:0]   va;
        logic [PAGE_W-1:0]   frame;
        logic [FLAG_W-1:0]   fl;
    } t_cmd;

    typedef struct packed {
        logic  valid;
        t_cmd  cmd;
    } t_head;

    typedef struct packed {
        logic  pop;
        logic  clearing;
    } t_back_ctl;

    typedef struct packed {
        logic                ok;
        logic [ADDR_W-1:0]   phys;
        logic [FLAG_W-1:0]   flags;
        logic                inval;
        logic [PAGE_W-1:0]   page;
    } t_result;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_DIR   = 4'b0100,
        ST_TBL   = 4'b1000
    } t_state;

endpackage

>>> rtl/core/two_level_page_table_manager.sv
// Channel   Direction  Handshake                 Payload
// in        to block   i_in_valid / o_in_stall   operation, space, vaddr, paddr, flags
// out       from block o_out_valid / i_out_stall ok, phys, flags, invalidate, page
// config    to block   psel/penable/pwrite/pready active space at address 0
//
// In the back end each item passes a directory read, a dependent table read, then
// table write-back with the result registered; the two memory ports set this order.
// After reset a clearing pass (one table entry a cycle, and one directory entry
// alongside until the directory is done) runs before the first item is taken.
// A two-item queue decouples input from the back end; a stalled output holds the
// back end in its write-back step while the queue keeps filling.
module two_level_page_table_manager (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tptm_pkg::OP_W-1:0]     i_operation,
    input  logic [tptm_pkg::SPACE_W-1:0]  i_space_index,
    input  logic [tptm_pkg::ADDR_W-1:0]   i_virt_addr,
    input  logic [tptm_pkg::ADDR_W-1:0]   i_phys_addr_in,
    input  logic [tptm_pkg::FLAG_W-1:0]   i_flag_bits,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_ok,
    output logic [tptm_pkg::ADDR_W-1:0]   o_phys_addr_out,
    output logic [tptm_pkg::FLAG_W-1:0]   o_flags_out,
    output logic                          o_invalidate,
    output logic [tptm_pkg::PAGE_W-1:0]   o_invalidate_page,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import tptm_pkg::*;

    logic [SPACE_W-1:0] r_cur_space;
    logic               reg_sel;
    t_head              head;
    t_back_ctl          ctl;
    t_result            result;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == 1'b0);
    assign prdata  = reg_sel ? {{(32 - SPACE_W){1'b0}}, r_cur_space} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_space <= '0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_cur_space <= pwdata[SPACE_W-1:0];
        end
    end

    tptm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_space_index  (i_space_index),
        .i_virt_addr    (i_virt_addr),
        .i_phys_addr_in (i_phys_addr_in),
        .i_flag_bits    (i_flag_bits),
        .i_ctl          (ctl),
        .o_head         (head)
    );

    tptm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_ctl       (ctl),
        .i_cur_space (r_cur_space),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    assign o_ok              = result.ok;
    assign o_phys_addr_out   = result.phys;
    assign o_flags_out       = result.flags;
    assign o_invalidate      = result.inval;
    assign o_invalidate_page = result.page;

endmodule

>>> rtl/core/tptm_front.sv
module tptm_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tptm_pkg::OP_W-1:0]     i_operation,
    input  logic [tptm_pkg::SPACE_W-1:0]  i_space_index,
    input  logic [tptm_pkg::ADDR_W-1:0]   i_virt_addr,
    input  logic [tptm_pkg::ADDR_W-1:0]   i_phys_addr_in,
    input  logic [tptm_pkg::FLAG_W-1:0]   i_flag_bits,
    input  tptm_pkg::t_back_ctl           i_ctl,
    output tptm_pkg::t_head               o_head
);
    import tptm_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_wp;
    logic       n_rp;
    logic [1:0] n_cnt;
    t_cmd       cmd;
    logic       push;
    logic       pop;

    always_comb begin
        cmd          = '0;
        cmd.space    = i_space_index;
        cmd.va       = i_virt_addr;
        cmd.frame    = i_phys_addr_in[ADDR_W-1:TBL_SHIFT];
        cmd.fl       = i_flag_bits;
        cmd.space_ok = ({1'b0, i_space_index} < (SPACE_W + 1)'(NUM_SPACES))
                       || (NUM_SPACES >= (1 << SPACE_W));
        case (i_operation)
            OP_MAP:       cmd.is_map   = 1'b1;
            OP_UNMAP:     cmd.is_unmap = 1'b1;
            OP_SET_FLAGS: cmd.is_set   = 1'b1;
            OP_CLR_FLAGS: cmd.is_clr   = 1'b1;
            OP_XLATE:     cmd.is_xlate = 1'b1;
            OP_GET_FLAGS: cmd.is_getf  = 1'b1;
            default:      cmd.is_map   = 1'b0;
        endcase
    end

    assign o_in_stall   = (r_cnt == 2'd2) || i_ctl.clearing;
    assign push         = i_in_valid && !o_in_stall;
    assign pop          = i_ctl.pop && (r_cnt != 2'd0);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cmd   = r_q[r_rp];

    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

endmodule

>>> rtl/core/tptm_back.sv
module tptm_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tptm_pkg::t_head               i_head,
    output tptm_pkg::t_back_ctl           o_ctl,
    input  logic [tptm_pkg::SPACE_W-1:0]  i_cur_space,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output tptm_pkg::t_result             o_result
);
    import tptm_pkg::*;

    logic [TBL_W:0]       dir_mem [DIR_DEPTH];
    logic [ADDR_W-1:0]    tab_mem [TAB_DEPTH];

    t_state               r_state;
    t_state               n_state;
    logic [CLR_W-1:0]     r_clr_cnt;
    logic [CNT_W-1:0]     r_free;
    t_cmd                 r_cmd;
    logic [DIR_AW-1:0]    r_dir_addr;
    logic [TAB_AW-1:0]    r_tab_addr;
    logic                 r_hit;
    logic [TBL_W:0]       r_dir_q;
    logic [ADDR_W-1:0]    r_tab_q;
    logic                 r_out_valid;
    t_result              r_out;

    logic                 dir_re;
    logic [DIR_AW-1:0]    dir_raddr;
    logic                 dir_we;
    logic [DIR_AW-1:0]    dir_waddr;
    logic [TBL_W:0]       dir_wdata;
    logic                 tab_re;
    logic [TAB_AW-1:0]    tab_raddr;
    logic                 tab_we;
    logic [TAB_AW-1:0]    tab_waddr;
    logic [ADDR_W-1:0]    tab_wdata;

    logic                 clr_last;
    logic                 out_free;
    logic                 dir_present;
    logic                 alloc;
    logic                 hit;
    logic [TBL_W-1:0]     tidx;
    logic                 ent_present;
    logic                 wrote;
    logic [ADDR_W-1:0]    new_entry;
    t_result              res;

    assign clr_last  = (r_clr_cnt == CLR_W'(CLR_DEPTH - 1));
    assign out_free  = !r_out_valid || !i_out_stall;

    assign o_ctl.pop      = (r_state == ST_IDLE) && i_head.valid;
    assign o_ctl.clearing = (r_state == ST_CLEAR);

    // Directory lookup and table allocation
    assign dir_present = r_cmd.space_ok && r_dir_q[TBL_W];
    assign alloc = r_cmd.is_map && r_cmd.space_ok && !r_dir_q[TBL_W]
                   && (r_free < CNT_W'(NUM_TABLES));
    assign hit   = dir_present || alloc;
    assign tidx  = dir_present ? r_dir_q[TBL_W-1:0] : r_free[TBL_W-1:0];

    assign dir_re    = o_ctl.pop;
    assign dir_raddr = DIR_AW'({i_head.cmd.space, i_head.cmd.va[ADDR_W-1:DIR_SHIFT]});
    assign tab_re    = (r_state == ST_DIR);
    assign tab_raddr = TAB_AW'({tidx, r_cmd.va[DIR_SHIFT-1:TBL_SHIFT]});

    always_comb begin
        dir_we    = 1'b0;
        dir_waddr = r_dir_addr;
        dir_wdata = {1'b1, r_free[TBL_W-1:0]};
        if (r_state == ST_CLEAR) begin
            dir_we    = ({1'b0, r_clr_cnt} < (CLR_W + 1)'(DIR_DEPTH));
            dir_waddr = r_clr_cnt[DIR_AW-1:0];
            dir_wdata = '0;
        end else if (r_state == ST_DIR) begin
            dir_we = alloc;
        end
    end

    // Entry update and result
    assign ent_present = r_hit && r_tab_q[0];

    always_comb begin
        res       = '0;
        res.ok    = 1'b1;
        wrote     = 1'b0;
        new_entry = r_tab_q;
        if (r_cmd.is_map) begin
            res.ok    = r_hit;
            wrote     = r_hit;
            new_entry = {r_cmd.frame, r_cmd.fl} | PRESENT_BIT;
        end else if (r_cmd.is_unmap) begin
            wrote     = ent_present;
            new_entry = '0;
        end else if (r_cmd.is_set) begin
            wrote     = ent_present;
            new_entry = r_tab_q | {{PAGE_W{1'b0}}, r_cmd.fl};
        end else if (r_cmd.is_clr) begin
            wrote     = ent_present;
            new_entry = r_tab_q & ~{{PAGE_W{1'b0}}, r_cmd.fl};
        end else if (r_cmd.is_xlate) begin
            if (ent_present) begin
                res.phys = {r_tab_q[ADDR_W-1:TBL_SHIFT], r_cmd.va[TBL_SHIFT-1:0]};
            end
        end else if (r_cmd.is_getf) begin
            if (ent_present) begin
                res.flags = r_tab_q[FLAG_W-1:0];
            end
        end
        if (wrote && (r_cmd.space == i_cur_space)) begin
            res.inval = 1'b1;
            res.page  = r_cmd.va[ADDR_W-1:TBL_SHIFT];
        end
    end

    always_comb begin
        tab_we    = 1'b0;
        tab_waddr = r_tab_addr;
        tab_wdata = new_entry;
        if (r_state == ST_CLEAR) begin
            tab_we    = ({1'b0, r_clr_cnt} < (CLR_W + 1)'(TAB_DEPTH));
            tab_waddr = r_clr_cnt[TAB_AW-1:0];
            tab_wdata = '0;
        end else if (r_state == ST_TBL) begin
            tab_we = out_free && wrote;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (clr_last) n_state = ST_IDLE;
            ST_IDLE:  if (i_head.valid) n_state = ST_DIR;
            ST_DIR:   n_state = ST_TBL;
            ST_TBL:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_free      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + CLR_W'(1);
            end
            if (r_state == ST_DIR && alloc) begin
                r_free <= r_free + CNT_W'(1);
            end
            r_out_valid <= (r_out_valid && i_out_stall)
                           || (r_state == ST_TBL && out_free);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ctl.pop) begin
            r_cmd      <= i_head.cmd;
            r_dir_addr <= dir_raddr;
        end
        if (r_state == ST_DIR) begin
            r_hit      <= hit;
            r_tab_addr <= tab_raddr;
        end
        if (r_state == ST_TBL && out_free) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dir_we) begin
            dir_mem[dir_waddr] <= dir_wdata;
        end
        if (dir_re) begin
            r_dir_q <= dir_mem[dir_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            tab_mem[tab_waddr] <= tab_wdata;
        end
        if (tab_re) begin
            r_tab_q <= tab_mem[tab_raddr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

>>> tb/page_walk_checker.sv
`timescale 1ns / 1ps
module page_walk_checker #(
    parameter logic [2:0] CUR_SPACE_ADDR = 3'd0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [tptm_pkg::OP_W-1:0]     i_operation,
    input  logic [tptm_pkg::SPACE_W-1:0]  i_space_index,
    input  logic [tptm_pkg::ADDR_W-1:0]   i_virt_addr,
    input  logic [tptm_pkg::ADDR_W-1:0]   i_phys_addr_in,
    input  logic [tptm_pkg::FLAG_W-1:0]   i_flag_bits,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic                          i_ok,
    input  logic [tptm_pkg::ADDR_W-1:0]   i_phys_addr_out,
    input  logic [tptm_pkg::FLAG_W-1:0]   i_flags_out,
    input  logic                          i_invalidate,
    input  logic [tptm_pkg::PAGE_W-1:0]   i_invalidate_page,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    input  logic                          pready,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked,
    output int                            o_map_refused
);
    import tptm_pkg::*;

    logic               dir_present [DIR_DEPTH];
    logic [TBL_W-1:0]   dir_table   [DIR_DEPTH];
    logic [ADDR_W-1:0]  pte_store   [TAB_DEPTH];
    int unsigned        tables_taken;
    logic [SPACE_W-1:0] active_space;
    t_result            expected_results [$];

    // Walk directory and table for one item, apply its change, return its result.
    function automatic t_result walk_and_update(input logic [OP_W-1:0]    op,
                                                input logic [SPACE_W-1:0] space,
                                                input logic [ADDR_W-1:0]  va,
                                                input logic [ADDR_W-1:0]  pa,
                                                input logic [FLAG_W-1:0]  fl);
        int      slot;
        int      entry;
        logic    found;
        logic    live;
        logic    wrote;
        t_result r;
        slot  = int'(space) * DIR_SLOTS + int'(va[ADDR_W-1:DIR_SHIFT]);
        found = dir_present[slot];
        entry = int'(dir_table[slot]) * ENTRIES_PER_TABLE
                + int'(va[DIR_SHIFT-1:TBL_SHIFT]);
        live  = found && pte_store[entry][0];
        wrote = 1'b0;
        r     = '0;
        r.ok  = 1'b1;
        case (op)
            OP_MAP: begin
                if (!found) begin
                    if (tables_taken < NUM_TABLES) begin
                        dir_present[slot] = 1'b1;
                        dir_table[slot]   = tables_taken[TBL_W-1:0];
                        entry = int'(tables_taken) * ENTRIES_PER_TABLE
                                + int'(va[DIR_SHIFT-1:TBL_SHIFT]);
                        tables_taken++;
                        found = 1'b1;
                    end else begin
                        r.ok = 1'b0;
                    end
                end
                if (found) begin
                    pte_store[entry] = {pa[ADDR_W-1:TBL_SHIFT], fl} | PRESENT_BIT;
                    wrote = 1'b1;
                end
            end
            OP_UNMAP: begin
                if (live) begin
                    pte_store[entry] = '0;
                    wrote = 1'b1;
                end
            end
            OP_SET_FLAGS: begin
                if (live) begin
                    pte_store[entry] = pte_store[entry] | {{PAGE_W{1'b0}}, fl};
                    wrote = 1'b1;
                end
            end
            OP_CLR_FLAGS: begin
                if (live) begin
                    pte_store[entry] = pte_store[entry] & ~{{PAGE_W{1'b0}}, fl};
                    wrote = 1'b1;
                end
            end
            OP_XLATE: begin
                if (live)
                    r.phys = {pte_store[entry][ADDR_W-1:TBL_SHIFT], va[TBL_SHIFT-1:0]};
            end
            OP_GET_FLAGS: begin
                if (live)
                    r.flags = pte_store[entry][FLAG_W-1:0];
            end
            default: ;
        endcase
        if (wrote && space == active_space) begin
            r.inval = 1'b1;
            r.page  = va[ADDR_W-1:TBL_SHIFT];
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [ADDR_W-1:0] want_v,
                               input logic [ADDR_W-1:0] got_v);
        if (want_v !== got_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result fresh;
        t_result want;
        if (!i_rst_n) begin
            for (int k = 0; k < DIR_DEPTH; k++) begin
                dir_present[k] = 1'b0;
                dir_table[k]   = '0;
            end
            for (int k = 0; k < TAB_DEPTH; k++)
                pte_store[k] = '0;
            tables_taken = 0;
            active_space = '0;
            expected_results.delete();
            o_pending = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == CUR_SPACE_ADDR)
                active_space = pwdata[SPACE_W-1:0];
            if (i_in_valid && !i_in_stall) begin
                fresh = walk_and_update(i_operation, i_space_index, i_virt_addr,
                                        i_phys_addr_in, i_flag_bits);
                if (!fresh.ok)
                    o_map_refused++;
                expected_results.push_back(fresh);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result item with nothing expected: ok=%0b phys=0x%0h flags=0x%0h",
                           i_ok, i_phys_addr_out, i_flags_out);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("ok", want.ok, i_ok);
                    check_field("phys_addr_out", want.phys, i_phys_addr_out);
                    check_field("flags_out", want.flags, i_flags_out);
                    check_field("invalidate", want.inval, i_invalidate);
                    check_field("invalidate_page", want.page, i_invalidate_page);
                    o_checked++;
                end
            end
            o_pending = expected_results.size();
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import tptm_pkg::*;

    localparam logic [2:0]      REG_CUR_SPACE = 3'd0;
    localparam logic [OP_W-1:0] OP_SPARE_6    = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7    = 3'd7;
    // Directory slots and table rows that random items keep returning to
    localparam logic [49:0] HOT_DIRS = {10'h3FF, 10'h200, 10'h155, 10'h001, 10'h000};
    localparam logic [59:0] HOT_ROWS = {10'h3FF, 10'h2AA, 10'h155, 10'h0F0, 10'h001,
                                        10'h000};
    localparam int DRAIN_LIMIT = 100000;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_stall;
    logic [OP_W-1:0]     operation     = '0;
    logic [SPACE_W-1:0]  space_index   = '0;
    logic [ADDR_W-1:0]   virt_addr     = '0;
    logic [ADDR_W-1:0]   phys_addr_in  = '0;
    logic [FLAG_W-1:0]   flag_bits     = '0;
    logic                out_valid;
    logic                out_stall     = 1'b0;
    logic                ok;
    logic [ADDR_W-1:0]   phys_addr_out;
    logic [FLAG_W-1:0]   flags_out;
    logic                invalidate;
    logic [PAGE_W-1:0]   invalidate_page;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [2:0]          paddr         = '0;
    logic [31:0]         pwdata        = '0;
    logic [31:0]         prdata;
    logic                pready;

    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    int   hold_req_len  = 0;
    int   hold_left     = 0;
    int   items_sent    = 0;
    int   settings_seen = 0;
    logic drain_stuck   = 1'b0;
    int   fail_count;
    int   pending;
    int   checked;
    int   map_refused;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    two_level_page_table_manager i_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_operation       (operation),
        .i_space_index     (space_index),
        .i_virt_addr       (virt_addr),
        .i_phys_addr_in    (phys_addr_in),
        .i_flag_bits       (flag_bits),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_ok              (ok),
        .o_phys_addr_out   (phys_addr_out),
        .o_flags_out       (flags_out),
        .o_invalidate      (invalidate),
        .o_invalidate_page (invalidate_page),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    page_walk_checker #(
        .CUR_SPACE_ADDR (REG_CUR_SPACE)
    ) u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_operation       (operation),
        .i_space_index     (space_index),
        .i_virt_addr       (virt_addr),
        .i_phys_addr_in    (phys_addr_in),
        .i_flag_bits       (flag_bits),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_ok              (ok),
        .i_phys_addr_out   (phys_addr_out),
        .i_flags_out       (flags_out),
        .i_invalidate      (invalidate),
        .i_invalidate_page (invalidate_page),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .pready            (pready),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_checked         (checked),
        .o_map_refused     (map_refused)
    );

    // Result side: random stall, or a long hold when one is requested
    always @(negedge clk) begin
        if (hold_req_len > 0) begin
            hold_left    = hold_req_len;
            hold_req_len = 0;
        end
        if (hold_left > 0) begin
            out_stall = 1'b1;
            hold_left--;
        end else begin
            out_stall = ($urandom_range(99) < stall_pct);
        end
    end

    task automatic push_item(input logic [OP_W-1:0]    op,
                             input logic [SPACE_W-1:0] sp,
                             input logic [ADDR_W-1:0]  va,
                             input logic [ADDR_W-1:0]  pa,
                             input logic [FLAG_W-1:0]  fl);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid     = 1'b1;
        operation    = op;
        space_index  = sp;
        virt_addr    = va;
        phys_addr_in = pa;
        flag_bits    = fl;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic push_random();
        int                 pick;
        int                 k;
        logic [OP_W-1:0]    op;
        logic [SPACE_W-1:0] sp;
        logic [ADDR_W-1:0]  va;
        logic [ADDR_W-1:0]  pa;
        logic [FLAG_W-1:0]  fl;
        sp   = SPACE_W'($urandom_range(NUM_SPACES - 1));
        pa   = $urandom;
        fl   = FLAG_W'($urandom_range(4095));
        pick = $urandom_range(99);
        if (pick < 12) begin
            // noise: any code, any address
            op = OP_W'($urandom_range(7));
            va = $urandom;
        end else begin
            k           = $urandom_range(4);
            va[31:22]   = HOT_DIRS[10*k +: 10];
            k           = $urandom_range(5);
            va[21:12]   = HOT_ROWS[10*k +: 10];
            va[11:0]    = 12'($urandom_range(4095));
            pick = $urandom_range(99);
            if (pick < 30)      op = OP_MAP;
            else if (pick < 40) op = OP_UNMAP;
            else if (pick < 52) op = OP_SET_FLAGS;
            else if (pick < 64) op = OP_CLR_FLAGS;
            else if (pick < 82) op = OP_XLATE;
            else                op = OP_GET_FLAGS;
        end
        // keep most entries present through a clear
        if (op == OP_CLR_FLAGS && $urandom_range(3) != 0)
            fl[0] = 1'b0;
        push_item(op, sp, va, pa, fl);
    endtask

    task automatic wait_drained();
        int guard;
        guard    = 0;
        in_valid = 1'b0;
        while (pending != 0 && guard < DRAIN_LIMIT) begin
            @(negedge clk);
            guard++;
        end
        if (pending != 0)
            drain_stuck = 1'b1;
    endtask

    task automatic write_active_space(input logic [SPACE_W-1:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = REG_CUR_SPACE;
        pwdata  = {{(32-SPACE_W){1'b0}}, value};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        settings_seen++;
    endtask

    task automatic run_phase(input int n, input int sidle, input int rstall,
                             input logic [SPACE_W-1:0] cs, input logic pause_mid,
                             input int hold_len);
        wait_drained();
        write_active_space(cs);
        send_idle_pct = sidle;
        stall_pct     = rstall;
        for (int i = 0; i < n; i++) begin
            if (pause_mid && i == n / 2)
                wait_drained();
            if (hold_len > 0 && i == 10)
                hold_req_len = hold_len;
            push_random();
        end
        in_valid = 1'b0;
    endtask

    initial begin
        #2_000_000;
        $display("two_level_page_table_manager test failed");
        $finish;
    end

    initial begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        // hold off until the clearing pass lets items in
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        write_active_space(2'd0);

        push_item(OP_XLATE,     2'd0, 32'h0000_0000, 32'h0, 12'h000);
        push_item(OP_GET_FLAGS, 2'd0, 32'h0000_0000, 32'h0, 12'h000);
        push_item(OP_UNMAP,     2'd0, 32'h0000_0000, 32'h0, 12'h000);
        push_item(OP_SET_FLAGS, 2'd0, 32'h0000_0000, 32'h0, 12'hFFF);
        push_item(OP_CLR_FLAGS, 2'd0, 32'h0000_0000, 32'h0, 12'hFFF);
        push_item(OP_MAP,       2'd0, 32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
        push_item(OP_XLATE,     2'd0, 32'h0000_0FFF, 32'h0, 12'h000);
        push_item(OP_MAP,       2'd0, 32'hFFFF_FFFF, 32'h0000_0000, 12'h000);
        push_item(OP_XLATE,     2'd0, 32'hFFFF_FFFF, 32'h0, 12'h000);
        push_item(OP_SET_FLAGS, 2'd0, 32'hFFFF_F000, 32'h0, 12'hFFE);
        push_item(OP_CLR_FLAGS, 2'd0, 32'hFFFF_F000, 32'h0, 12'h0F0);
        push_item(OP_GET_FLAGS, 2'd0, 32'hFFFF_FABC, 32'h0, 12'h000);
        // clearing the present bit unmaps the entry
        push_item(OP_CLR_FLAGS, 2'd0, 32'hFFFF_F000, 32'h0, 12'h001);
        push_item(OP_XLATE,     2'd0, 32'hFFFF_F123, 32'h0, 12'h000);
        push_item(OP_GET_FLAGS, 2'd0, 32'hFFFF_F123, 32'h0, 12'h000);
        push_item(OP_SET_FLAGS, 2'd0, 32'hFFFF_F000, 32'h0, 12'h001);
        push_item(OP_MAP,       2'd3, 32'h8040_1234, 32'hA5A5_A5A5, 12'h5A5);
        push_item(OP_XLATE,     2'd3, 32'h8040_1FFF, 32'h0, 12'h000);
        push_item(OP_MAP,       2'd0, 32'h0000_0000, 32'h1234_5000, 12'h00A);
        push_item(OP_UNMAP,     2'd0, 32'h0000_0ABC, 32'h0, 12'h000);
        push_item(OP_XLATE,     2'd0, 32'h0000_0000, 32'h0, 12'h000);
        push_item(OP_SPARE_6,   2'd2, 32'h5555_5555, 32'hAAAA_AAAA, 12'h555);
        push_item(OP_SPARE_7,   2'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
        push_item(OP_MAP,       2'd1, 32'h0000_1000, 32'h7000_0000, 12'h800);
        in_valid = 1'b0;

        run_phase(100,  0,  0, 2'd3, 1'b0, 0);
        run_phase(100, 74,  0, 2'd1, 1'b1, 0);
        run_phase(100,  0, 74, 2'd2, 1'b0, 0);
        run_phase(150, 23, 23, 2'd0, 1'b0, 0);
        run_phase(130,  0,  0, 2'd3, 1'b0, 60);

        wait_drained();
        stall_pct = 0;
        repeat (20) @(negedge clk);
        $display("Covered %0d items over %0d active-space settings, with idle, stall and",
                 items_sent, settings_seen);
        $display("long-hold mixes; %0d results compared, %0d maps refused for an empty pool.",
                 checked, map_refused);
        if (fail_count == 0 && pending == 0 && !drain_stuck)
            $display("two_level_page_table_manager test passed");
        else
            $display("two_level_page_table_manager test failed");
        $finish;
    end

endmodule
